// ===== rtl/pcs_pkg.sv =====
// Shared types, constants and elaboration-time functions for the percentile
// contrast stretch block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

    localparam int BIN_AW   = 8;
    localparam int BIN_N    = 256;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] CFG_GAMMA    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_LOW_CUT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HIGH_CUT = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FLUSH,
        ST_WALK,
        ST_BUILD,
        ST_CURVE,
        ST_RES_RD,
        ST_RES_WR
    } t_ctl_state;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_DIV,
        CV_NORM,
        CV_LOG,
        CV_EXP,
        CV_POW,
        CV_ROUND
    } t_crv_state;

    // One curve evaluation request from the map builder.
    typedef struct packed {
        logic        start;
        logic [7:0]  offset;
        logic [7:0]  span;
        logic [15:0] gamma;
    } t_curve_req;

    // Integer square root, evaluated only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q30, by repeated square roots starting from 2.0.
    function automatic logic [31:0] root_q30(input int k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 1; i <= 16; i++) begin
            if (i <= k) begin
                r = isqrt64(r << 30);
            end
        end
        return r[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pcs_curve.sv =====
// Multi-cycle gamma curve unit: restoring divide, log2 by squaring,
// multiply by gamma, and 2^x by a product of stored roots. Uses pcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcs_curve (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pcs_pkg::t_curve_req i_req,
    output logic                     o_done,
    output logic [7:0]               o_value
);
    import pcs_pkg::*;

    localparam logic [31:0] ROOT_TBL [16] = '{
        root_q30(1),  root_q30(2),  root_q30(3),  root_q30(4),
        root_q30(5),  root_q30(6),  root_q30(7),  root_q30(8),
        root_q30(9),  root_q30(10), root_q30(11), root_q30(12),
        root_q30(13), root_q30(14), root_q30(15), root_q30(16)
    };

    t_crv_state  r_cst, n_cst;
    logic [4:0]  r_step;
    logic [33:0] r_rem;
    logic [31:0] r_den;
    logic [23:0] r_q;
    logic [2:0]  r_e;
    logic [30:0] r_m;
    logic [15:0] r_frac;
    logic [15:0] r_gamma;
    logic [2:0]  r_n;
    logic [15:0] r_f;
    logic [30:0] r_a;
    logic [3:0]  r_k;
    logic [7:0]  r_val;
    logic        r_done;

    logic [15:0] d255;
    logic        div_ge;
    logic [2:0]  norm_e;
    logic [37:0] norm_m;
    logic [61:0] sq;
    logic [34:0] lg_prod;
    logic [35:0] p_sum;
    logic [23:0] p_val;
    logic [61:0] a_prod;
    logic [38:0] rnd;
    logic [8:0]  y;

    always_comb begin
        d255    = {i_req.offset, 8'd0} - {8'd0, i_req.offset};
        div_ge  = r_rem >= {2'b00, r_den};
        if (r_q[23]) begin
            norm_e = 3'd7;
        end else if (r_q[22]) begin
            norm_e = 3'd6;
        end else if (r_q[21]) begin
            norm_e = 3'd5;
        end else if (r_q[20]) begin
            norm_e = 3'd4;
        end else if (r_q[19]) begin
            norm_e = 3'd3;
        end else if (r_q[18]) begin
            norm_e = 3'd2;
        end else if (r_q[17]) begin
            norm_e = 3'd1;
        end else begin
            norm_e = 3'd0;
        end
        norm_m  = {14'd0, r_q} << (4'd14 - {1'b0, norm_e});
        sq      = 62'(r_m) * 62'(r_m);
        lg_prod = 35'({r_e, r_frac}) * 35'(r_gamma);
        p_sum   = {1'b0, lg_prod} + 36'd2048;
        p_val   = p_sum[35:12];
        a_prod  = 62'(r_a) * 62'(ROOT_TBL[r_k][30:0]);
        rnd     = ({8'd0, r_a} << r_n) + (39'd1 << 29);
        y       = rnd[38:30];
    end

    always_comb begin
        n_cst = r_cst;
        case (r_cst)
            CV_IDLE:  if (i_req.start) n_cst = CV_DIV;
            CV_DIV:   if (r_step == 5'd0) n_cst = CV_NORM;
            CV_NORM:  n_cst = CV_LOG;
            CV_LOG:   if (r_step == 5'd0) n_cst = CV_EXP;
            CV_EXP:   n_cst = (p_val[23:19] != 5'd0) ? CV_IDLE : CV_POW;
            CV_POW:   if (r_k == 4'd15) n_cst = CV_ROUND;
            CV_ROUND: n_cst = CV_IDLE;
            default:  n_cst = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst  <= CV_IDLE;
            r_done <= 1'b0;
        end else begin
            r_cst  <= n_cst;
            r_done <= ((r_cst == CV_EXP) && (p_val[23:19] != 5'd0)) || (r_cst == CV_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cst)
            CV_IDLE: begin
                r_rem   <= {1'b0, d255, 17'd0} + {26'd0, i_req.span};
                r_den   <= {15'd0, i_req.span, 1'b0, 8'd0} << 15;
                r_q     <= '0;
                r_step  <= 5'd23;
                r_gamma <= i_req.gamma;
            end
            CV_DIV: begin
                if (div_ge) begin
                    r_rem <= r_rem - {2'b00, r_den};
                end
                r_q    <= {r_q[22:0], div_ge};
                r_den  <= r_den >> 1;
                r_step <= r_step - 5'd1;
            end
            CV_NORM: begin
                r_e    <= norm_e;
                r_m    <= norm_m[30:0];
                r_frac <= '0;
                r_step <= 5'd15;
            end
            CV_LOG: begin
                r_m    <= sq[61] ? sq[61:31] : sq[60:30];
                r_frac <= {r_frac[14:0], sq[61]};
                r_step <= r_step - 5'd1;
            end
            CV_EXP: begin
                r_val <= 8'd255;
                r_n   <= p_val[18:16];
                r_f   <= p_val[15:0];
                r_a   <= 31'd1 << 30;
                r_k   <= 4'd0;
            end
            CV_POW: begin
                if (r_f[15]) begin
                    r_a <= a_prod[60:30];
                end
                r_f <= {r_f[14:0], 1'b0};
                r_k <= r_k + 4'd1;
            end
            CV_ROUND: begin
                r_val <= y[8] ? 8'd255 : y[7:0];
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_val;

endmodule
`default_nettype wire

// ===== rtl/percentile_contrast_stretch.sv =====
// Top level of the percentile contrast stretch block. Holds the histogram
// and tone map memories and the control sequencer. Uses pcs_pkg, pcs_ram
// and pcs_curve.
`timescale 1ns / 1ps
`default_nettype none
// Percentile contrast stretch with a gamma curve for 8-bit gray pixels.
// Accumulate beats (mode 0) are counted into a 256-bin histogram held in a
// RAM, one beat per cycle unless stalled; a count update is a read, an
// increment in the next cycle and a write back, with the last written
// value forwarded when the same bin is hit twice in a row. A map beat
// (mode 1) reads the tone map RAM and returns its result through the RAM
// read register and the output register, so map beats also flow at one
// per cycle while the output is taken. The accumulate beat marked last
// returns no result until the map is rebuilt: a flush state settles the
// final count, a walk of the histogram finds both cutoff bins and zeroes
// every bin, then a 256-entry build of the tone map follows. Entries at or
// outside the cutoffs are written directly; each entry between them runs
// through one shared curve unit (divide, log2, gamma multiply, power),
// which finishes early when the curve saturates. After reset a clearing
// pass zeroes both memories; input beats are held off during it and
// during a rebuild. Configuration writes are always accepted, and should be
// issued only while the block is idle.
module percentile_contrast_stretch #(
    parameter int MAX_PIXELS_LOG2 = 22
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_mode,
    input  wire logic [7:0]                 i_pixel,
    input  wire logic                       i_last,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [7:0]                      o_mapped_pixel,
    output logic [7:0]                      o_low_bin,
    output logic [7:0]                      o_high_bin,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [pcs_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [15:0]                i_cfg_data
);
    import pcs_pkg::*;

    // A count can reach 2^MAX_PIXELS_LOG2, so one extra bit.
    localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
    localparam int PROD_W = CNT_W + 16;

    t_ctl_state r_state, n_state;
    logic [8:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0] r_total;
    logic             r_s1_acc;
    logic             r_s1_map;
    logic [7:0]       r_s1_pix;
    logic             r_w_en;
    logic [7:0]       r_w_pix;
    logic [CNT_W-1:0] r_w_val;
    logic [7:0]       r_last_pix;
    logic [7:0]       r_lo;
    logic [7:0]       r_hi;
    logic             r_lo_open;
    logic             r_hi_open;
    logic [CNT_W-1:0] r_cum;
    logic [PROD_W-1:0] r_low_prod;
    logic [PROD_W-1:0] r_high_prod;
    logic             r_rv;
    logic [7:0]       r_ridx;
    logic [15:0]      r_gamma;
    logic [15:0]      r_low_cut;
    logic [15:0]      r_high_cut;
    logic             r_out_valid;
    logic [7:0]       r_out_pix;
    logic [7:0]       r_out_lo;
    logic [7:0]       r_out_hi;

    logic             out_free;
    logic             s1_block;
    logic             in_ready;
    logic             in_acc;
    logic             counted;
    logic             out_load;
    logic [CNT_W-1:0] hist_rdata;
    logic [CNT_W-1:0] inc_val;
    logic [CNT_W-1:0] cum_n;
    logic [PROD_W-1:0] cum_sh;
    logic             hist_we;
    logic [7:0]       hist_waddr;
    logic [CNT_W-1:0] hist_wdata;
    logic             hist_re;
    logic [7:0]       hist_raddr;
    logic             map_we;
    logic [7:0]       map_waddr;
    logic [7:0]       map_wdata;
    logic             map_re;
    logic [7:0]       map_raddr;
    logic [7:0]       map_rdata;
    logic [7:0]       idx;
    logic             build_low;
    logic             build_high;
    logic             walk_end;
    logic             entry_done;
    t_curve_req       curve_req;
    logic             curve_done;
    logic [7:0]       curve_value;

    // A map result in the first stage needs the output register; while it
    // cannot move, the map RAM read data must hold, so no new beat enters.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_block   = r_s1_map && !out_free;
    assign in_ready   = (r_state == ST_RUN) && !s1_block;
    assign in_acc     = i_in_valid && in_ready;
    assign counted    = !r_total[CNT_W-1];
    assign o_in_stall = !in_ready;
    assign o_cfg_ready = 1'b1;

    // Forward the count written at the same edge as this bin was read.
    assign inc_val = ((r_w_en && (r_w_pix == r_s1_pix)) ? r_w_val : hist_rdata)
                     + CNT_W'(1);
    assign cum_n   = r_cum + hist_rdata;
    assign cum_sh  = {cum_n, 16'd0};
    assign walk_end = r_rv && (r_ridx == 8'd255);

    assign idx        = r_cnt[7:0];
    assign build_low  = idx <= r_lo;
    assign build_high = idx >= r_hi;
    assign entry_done = ((r_state == ST_BUILD) && (build_low || build_high))
                        || ((r_state == ST_CURVE) && curve_done);

    assign curve_req.start  = (r_state == ST_BUILD) && !build_low && !build_high;
    assign curve_req.offset = idx - r_lo;
    assign curve_req.span   = r_hi - r_lo;
    assign curve_req.gamma  = r_gamma;

    assign out_load = out_free && (r_s1_map || (r_state == ST_RES_WR));

    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = idx;
        hist_wdata = '0;
        if (r_state == ST_CLEAR) begin
            hist_we = 1'b1;
        end else if (r_s1_acc) begin
            hist_we    = 1'b1;
            hist_waddr = r_s1_pix;
            hist_wdata = inc_val;
        end else if (r_rv) begin
            hist_we    = 1'b1;
            hist_waddr = r_ridx;
        end
        hist_re    = (in_acc && !i_mode) || ((r_state == ST_WALK) && !r_cnt[8]);
        hist_raddr = (r_state == ST_WALK) ? idx : i_pixel;

        map_we    = (r_state == ST_CLEAR) || entry_done;
        map_waddr = idx;
        if (r_state == ST_CLEAR || (r_state == ST_BUILD && build_low)) begin
            map_wdata = 8'd0;
        end else if (r_state == ST_BUILD) begin
            map_wdata = 8'd255;
        end else begin
            map_wdata = curve_value;
        end
        map_re    = (in_acc && i_mode) || (r_state == ST_RES_RD);
        map_raddr = (r_state == ST_RES_RD) ? r_last_pix : i_pixel;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + 9'd1;
                if (idx == 8'd255) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (in_acc && !i_mode && i_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_WALK;
                n_cnt   = '0;
            end
            ST_WALK: begin
                if (!r_cnt[8]) begin
                    n_cnt = r_cnt + 9'd1;
                end
                if (walk_end) begin
                    n_state = ST_BUILD;
                    n_cnt   = '0;
                end
            end
            ST_BUILD, ST_CURVE: begin
                if (curve_req.start) begin
                    n_state = ST_CURVE;
                end else if (entry_done) begin
                    if (idx == 8'd255) begin
                        n_state = ST_RES_RD;
                    end else begin
                        n_state = ST_BUILD;
                        n_cnt   = r_cnt + 9'd1;
                    end
                end
            end
            ST_RES_RD: begin
                n_state = ST_RES_WR;
            end
            ST_RES_WR: begin
                if (out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_total     <= '0;
            r_s1_acc    <= 1'b0;
            r_s1_map    <= 1'b0;
            r_w_en      <= 1'b0;
            r_rv        <= 1'b0;
            r_lo        <= 8'd0;
            r_hi        <= 8'd255;
            r_out_valid <= 1'b0;
            r_gamma     <= 16'd4096;
            r_low_cut   <= 16'd655;
            r_high_cut  <= 16'd64880;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_s1_acc    <= in_acc && !i_mode && counted;
            r_s1_map    <= s1_block || (in_acc && i_mode);
            r_w_en      <= r_s1_acc;
            r_rv        <= (r_state == ST_WALK) && !r_cnt[8];
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            if (in_acc && !i_mode && counted) begin
                r_total <= r_total + CNT_W'(1);
            end else if (walk_end) begin
                r_total <= '0;
            end
            if (r_rv) begin
                if (r_lo_open && (cum_sh > r_low_prod)) begin
                    r_lo <= r_ridx;
                end
                if (r_hi_open && (cum_sh > r_high_prod)) begin
                    r_hi <= r_ridx;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAMMA:    r_gamma    <= i_cfg_data;
                    CFG_LOW_CUT:  r_low_cut  <= i_cfg_data;
                    CFG_HIGH_CUT: r_high_cut <= i_cfg_data;
                    default:      r_gamma    <= r_gamma;
                endcase
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_pixel;
        end
        if (in_acc && !i_mode && i_last) begin
            r_last_pix <= i_pixel;
        end
        r_w_pix <= r_s1_pix;
        r_w_val <= inc_val;
        r_ridx  <= idx;
        if (r_state == ST_FLUSH) begin
            r_low_prod  <= PROD_W'(r_low_cut) * PROD_W'(r_total);
            r_high_prod <= PROD_W'(r_high_cut) * PROD_W'(r_total);
            r_cum       <= '0;
            r_lo_open   <= 1'b1;
            r_hi_open   <= 1'b1;
        end else if (r_rv) begin
            r_cum <= cum_n;
            if (cum_sh > r_low_prod) begin
                r_lo_open <= 1'b0;
            end
            if (cum_sh > r_high_prod) begin
                r_hi_open <= 1'b0;
            end
        end
        if (out_load) begin
            r_out_pix <= map_rdata;
            r_out_lo  <= r_lo;
            r_out_hi  <= r_hi;
        end
    end

    pcs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BIN_N)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    pcs_ram #(
        .WIDTH (8),
        .DEPTH (BIN_N)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    pcs_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (curve_req),
        .o_done  (curve_done),
        .o_value (curve_value)
    );

    assign o_out_valid    = r_out_valid;
    assign o_mapped_pixel = r_out_pix;
    assign o_low_bin      = r_out_lo;
    assign o_high_bin     = r_out_hi;

endmodule
`default_nettype wire
